### sv/mtpq_pkg.sv
// ----------------------------------------------------------------------------
// mtpq_pkg
// Shared types and codes for the multilevel timed priority queue: channel
// items, slot contents, cell commands and per-level status.
// ----------------------------------------------------------------------------
package mtpq_pkg;

	// Item kinds on the request channel.
	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_SERVE  = 1'b1;

	// Result status codes.
	localparam logic [1:0] ST_INSERTED = 2'd0;
	localparam logic [1:0] ST_DROPPED  = 2'd1;
	localparam logic [1:0] ST_SERVED   = 2'd2;
	localparam logic [1:0] ST_EMPTY    = 2'd3;

	// Request item.
	typedef struct packed {
		logic        kind;
		logic [15:0] event_tag;
		logic [3:0]  level;
		logic [31:0] activation_time;
	} req_item_t;

	// Result item.
	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] served_tag;
		logic [3:0]  served_level;
		logic [31:0] served_time;
	} rsp_item_t;

	// Contents of one queue slot.
	typedef struct packed {
		logic [15:0] tag;
		logic [31:0] act_time;
	} slot_t;

	// Command broadcast to every cell of a level.
	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_INSERT = 2'd1,
		OP_SERVE  = 2'd2
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		slot_t    item;
	} cell_ctrl_t;

	// Status that a level reports to the top level.
	typedef struct packed {
		logic  nonempty;
		logic  full;
		slot_t head;
	} lvl_stat_t;

endpackage

### sv/mtpq_req_if.sv
// ----------------------------------------------------------------------------
// mtpq_req_if
// Valid/ready channel that carries request items into the queue.
// ----------------------------------------------------------------------------
interface mtpq_req_if;
	import mtpq_pkg::*;

	logic      valid;
	logic      ready;
	req_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### sv/mtpq_rsp_if.sv
// ----------------------------------------------------------------------------
// mtpq_rsp_if
// Valid/ready channel that carries result items out of the queue.
// ----------------------------------------------------------------------------
interface mtpq_rsp_if;
	import mtpq_pkg::*;

	logic      valid;
	logic      ready;
	rsp_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### sv/multilevel_timed_priority_queue.sv
// The result is registered in the output register when its item executes from the
// command register; the command register holds one item at a time, and ready
// stays low until that item executes and every level's cell row shifts.
// A waiting result in the output register stalls execution until it is taken.
// Reset (arst_n low) empties every level at once; slot contents are not cleared.
// ----------------------------------------------------------------------------
// multilevel_timed_priority_queue
// Multilevel priority queue of timed events. Each level is a sorted row of
// cells; a serve removes the earliest event of the highest nonempty level.
// ----------------------------------------------------------------------------
module multilevel_timed_priority_queue #(
	parameter int LEVELS      = 8,
	parameter int LEVEL_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	mtpq_req_if.sink          req,
	mtpq_rsp_if.source        rsp
);
	import mtpq_pkg::*;

	localparam int LVL_W = $clog2(LEVELS);

	req_item_t  cmd_q;
	logic       busy_q;
	rsp_item_t  rsp_q;
	logic       rsp_valid_q;
	logic       exec;

	lvl_stat_t  stat [LEVELS];
	cell_ctrl_t ctrl [LEVELS];

	logic             lvl_ok;
	logic [LVL_W-1:0] lvl_idx;
	logic             lvl_full;
	logic             ins_ok;
	logic             srv_found;
	logic [LVL_W-1:0] srv_idx;
	rsp_item_t        rsp_d;

	// Command register: one item at a time.
	assign req.ready = !busy_q;
	assign exec      = busy_q && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req.valid && req.ready) begin
			busy_q <= 1'b1;
		end else if (exec) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_q <= req.data;
		end
	end

	// Insert target level and its full flag.
	always_comb begin
		lvl_ok   = (cmd_q.level != 4'd0) && (int'(cmd_q.level) <= LEVELS);
		lvl_idx  = LVL_W'(cmd_q.level - 4'd1);
		lvl_full = 1'b0;
		for (int i = 0; i < LEVELS; i++) begin
			if (LVL_W'(i) == lvl_idx) begin
				lvl_full = stat[i].full;
			end
		end
		ins_ok = lvl_ok && !lvl_full;
	end

	// Highest nonempty level.
	always_comb begin
		srv_found = 1'b0;
		srv_idx   = '0;
		for (int i = 0; i < LEVELS; i++) begin
			if (stat[i].nonempty) begin
				srv_found = 1'b1;
				srv_idx   = LVL_W'(i);
			end
		end
	end

	// Commands to the levels.
	always_comb begin
		for (int i = 0; i < LEVELS; i++) begin
			ctrl[i].op            = OP_HOLD;
			ctrl[i].item.tag      = cmd_q.event_tag;
			ctrl[i].item.act_time = cmd_q.activation_time;
			if (exec) begin
				if (cmd_q.kind == KIND_INSERT && ins_ok && LVL_W'(i) == lvl_idx) begin
					ctrl[i].op = OP_INSERT;
				end else if (cmd_q.kind == KIND_SERVE && srv_found
						&& LVL_W'(i) == srv_idx) begin
					ctrl[i].op = OP_SERVE;
				end
			end
		end
	end

	for (genvar g = 0; g < LEVELS; g++) begin : g_level
		mtpq_level #(
			.DEPTH (LEVEL_DEPTH)
		) u_level (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl[g]),
			.stat   (stat[g])
		);
	end

	// Result of the executing item.
	always_comb begin
		rsp_d = '0;
		if (cmd_q.kind == KIND_INSERT) begin
			rsp_d.status = ins_ok ? ST_INSERTED : ST_DROPPED;
		end else if (srv_found) begin
			rsp_d.status       = ST_SERVED;
			rsp_d.served_tag   = stat[srv_idx].head.tag;
			rsp_d.served_level = 4'({1'b0, srv_idx} + 1'b1);
			rsp_d.served_time  = stat[srv_idx].head.act_time;
		end else begin
			rsp_d.status = ST_EMPTY;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (exec) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// An accepted request occupies the command register next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> busy_q)
		else $error("accepted request did not occupy the command register");

	// Execution always leaves a result in the output register.
	a_exec_result: assert property (@(posedge clk) disable iff (!arst_n)
		exec |=> rsp_valid_q)
		else $error("executed item produced no result");

	// A served result names a real level.
	a_served_level: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.status == ST_SERVED) |-> (rsp_q.served_level != 4'd0))
		else $error("served result carries level zero");

	// Non-served results carry zero payload.
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.status != ST_SERVED)
		|-> (rsp_q.served_tag == '0 && rsp_q.served_level == '0
			&& rsp_q.served_time == '0))
		else $error("non-served result carries nonzero fields");

endmodule

### sv/mtpq_cell.sv
// ----------------------------------------------------------------------------
// mtpq_cell
// One slot of a sorted level. On an insert the cell keeps its entry if it
// is earlier than the new time, otherwise it takes the new entry or the entry
// of its left neighbor. On a serve it takes its right neighbor's entry (the last cell keeps its own).
// ----------------------------------------------------------------------------
module mtpq_cell (
	input  logic                clk,
	input  mtpq_pkg::cell_ctrl_t ctrl,
	input  logic                occupied,
	input  logic                left_lt,
	input  mtpq_pkg::slot_t     left_slot,
	input  mtpq_pkg::slot_t     right_slot,
	output logic                lt,
	output mtpq_pkg::slot_t     slot
);
	import mtpq_pkg::*;

	slot_t slot_q;
	slot_t slot_d;

	// An occupied entry strictly earlier than the new time stays in place.
	assign lt   = occupied && (slot_q.act_time < ctrl.item.act_time);
	assign slot = slot_q;

	// Next slot contents.
	always_comb begin
		slot_d = slot_q;
		case (ctrl.op)
			OP_INSERT: begin
				if (!lt) begin
					slot_d = left_lt ? ctrl.item : left_slot;
				end
			end
			OP_SERVE: begin
				slot_d = right_slot;
			end
			default: begin
				slot_d = slot_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		slot_q <= slot_d;
	end

endmodule

### sv/mtpq_level.sv
// ----------------------------------------------------------------------------
// mtpq_level
// One priority level: a row of cells kept sorted by ascending activation
// time, plus the fill count that marks which cells hold entries.
// ----------------------------------------------------------------------------
module mtpq_level #(
	parameter int DEPTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mtpq_pkg::cell_ctrl_t ctrl,
	output mtpq_pkg::lvl_stat_t  stat
);
	import mtpq_pkg::*;

	localparam int FILL_W = $clog2(DEPTH + 1);

	logic [FILL_W-1:0] fill_q;
	logic [DEPTH-1:0]  occ;
	logic [DEPTH-1:0]  lt;
	slot_t             slots [DEPTH];

	// Cells below the fill count hold entries.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			occ[i] = (FILL_W'(i) < fill_q);
		end
	end

	// Row of cells; each sees its neighbors' entries and compare results.
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic  left_lt;
		slot_t left_slot;
		slot_t right_slot;

		if (g == 0) begin : g_first
			assign left_lt   = 1'b1;
			assign left_slot = ctrl.item;
		end else begin : g_mid
			assign left_lt   = lt[g-1];
			assign left_slot = slots[g-1];
		end

		if (g == DEPTH - 1) begin : g_last
			assign right_slot = slots[g];
		end else begin : g_inner
			assign right_slot = slots[g+1];
		end

		mtpq_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.occupied   (occ[g]),
			.left_lt    (left_lt),
			.left_slot  (left_slot),
			.right_slot (right_slot),
			.lt         (lt[g]),
			.slot       (slots[g])
		);
	end

	// Fill count follows inserts and serves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else begin
			case (ctrl.op)
				OP_INSERT: fill_q <= fill_q + 1'b1;
				OP_SERVE:  fill_q <= fill_q - 1'b1;
				default:   fill_q <= fill_q;
			endcase
		end
	end

	assign stat.nonempty = (fill_q != '0);
	assign stat.full     = (fill_q == FILL_W'(DEPTH));
	assign stat.head     = slots[0];

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multilevel timed priority queue. A directed table
// covers empty serves, out-of-range levels, extreme tags and times, equal-time
// ordering and a full level. A random section of insert and serve traffic
// follows. Each result is checked against its typed row's status or a behavioral
// model of the levels, with random sender gaps and receiver stalls throughout.
// ----------------------------------------------------------------------------
module tb_top;
	import mtpq_pkg::*;

	localparam int LEVELS      = 8;
	localparam int LEVEL_DEPTH = 16;
	localparam int SLOTS       = LEVELS * LEVEL_DEPTH;
	localparam int RANDOM_ITEMS = 600;
	localparam int IDLE_LIMIT   = 5000;
	localparam int DRAIN_CYCLES = 20;

	// One row of the directed table; typed rows carry their own expected status.
	typedef struct {
		req_item_t   item;
		bit          typed;
		logic [1:0]  want_status;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;

	mtpq_req_if req ();
	mtpq_rsp_if rsp ();

	multilevel_timed_priority_queue #(
		.LEVELS      (LEVELS),
		.LEVEL_DEPTH (LEVEL_DEPTH)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// Shadow copy of the level contents, earliest event first in each level.
	logic [15:0] tag_store [SLOTS];
	logic [31:0] time_store [SLOTS];
	int          depth_used [LEVELS];

	rsp_item_t awaited_results [$];
	plan_row_t directed_plan [$];
	int        mismatches = 0;
	int        burst_left = 0;
	int        idle_cycles = 0;

	// Clock with a 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one accepted item to the shadow levels and return its result.
	function automatic rsp_item_t scheduler_step(req_item_t it);
		rsp_item_t r;
		int        base;
		int        fill;
		int        pos;
		int        li;
		r = '0;
		if (it.kind == KIND_INSERT) begin
			if (it.level < 1 || it.level > LEVELS) begin
				r.status = ST_DROPPED;
				return r;
			end
			base = (int'(it.level) - 1) * LEVEL_DEPTH;
			fill = depth_used[it.level - 1];
			if (fill >= LEVEL_DEPTH) begin
				r.status = ST_DROPPED;
				return r;
			end
			// A new event goes ahead of every entry whose time is not smaller.
			pos = 0;
			while (pos < fill && time_store[base + pos] < it.activation_time)
				pos++;
			for (int i = fill; i > pos; i--) begin
				time_store[base + i] = time_store[base + i - 1];
				tag_store[base + i]  = tag_store[base + i - 1];
			end
			time_store[base + pos] = it.activation_time;
			tag_store[base + pos]  = it.event_tag;
			depth_used[it.level - 1] = fill + 1;
			r.status = ST_INSERTED;
			return r;
		end
		// Serve the head of the highest nonempty level.
		for (li = LEVELS - 1; li >= 0; li--) begin
			fill = depth_used[li];
			if (fill != 0) begin
				base = li * LEVEL_DEPTH;
				r.status       = ST_SERVED;
				r.served_tag   = tag_store[base];
				r.served_level = 4'(li + 1);
				r.served_time  = time_store[base];
				for (int i = 0; i + 1 < fill; i++) begin
					time_store[base + i] = time_store[base + i + 1];
					tag_store[base + i]  = tag_store[base + i + 1];
				end
				depth_used[li] = fill - 1;
				return r;
			end
		end
		r.status = ST_EMPTY;
		return r;
	endfunction

	function automatic void plan_row(logic kind, logic [15:0] tag, logic [3:0] lvl,
			logic [31:0] t, bit typed, logic [1:0] st);
		plan_row_t row;
		row.item.kind            = kind;
		row.item.event_tag       = tag;
		row.item.level           = lvl;
		row.item.activation_time = t;
		row.typed       = typed;
		row.want_status = st;
		directed_plan.push_back(row);
	endfunction

	// Random item; the insert share, level window and time spread vary by section.
	function automatic req_item_t random_item(int insert_pct, int lvl_lo, int lvl_hi,
			int time_mode);
		req_item_t it;
		it.kind      = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_SERVE;
		it.event_tag = 16'($urandom);
		if ($urandom_range(0, 99) < 5)
			it.level = 4'($urandom_range(0, 15));
		else
			it.level = 4'($urandom_range(lvl_lo, lvl_hi));
		case (time_mode)
			0: it.activation_time = $urandom;
			1: it.activation_time = $urandom_range(0, 7);
			default: begin
				case ($urandom_range(0, 2))
					0: it.activation_time = 32'h0;
					1: it.activation_time = 32'hFFFF_FFFF;
					default: it.activation_time = $urandom;
				endcase
			end
		endcase
		return it;
	endfunction

	task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, want, got);
	endtask

	// Offer one item, idling first when the current burst has run out.
	task automatic send_item(req_item_t it, bit typed, logic [1:0] want_status);
		int        gap;
		rsp_item_t model_out;
		rsp_item_t typed_out;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 10);
			if (gap > 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
		end
		burst_left--;
		req.valid <= 1'b1;
		req.data  <= it;
		@(posedge clk);
		while (req.ready !== 1'b1)
			@(posedge clk);
		model_out = scheduler_step(it);
		if (typed) begin
			typed_out = '0;
			typed_out.status = want_status;
			awaited_results.push_back(typed_out);
		end else begin
			awaited_results.push_back(model_out);
		end
	endtask

	// Receiver stalls: ready follows one of four patterns, each picked at random.
	initial begin
		int mode;
		int cyc;
		rsp.ready = 1'b0;
		mode = 0;
		cyc  = 0;
		forever begin
			@(posedge clk);
			if (cyc % 50 == 0)
				mode = $urandom_range(0, 3);
			case (mode)
				0: rsp.ready <= 1'b1;
				1: rsp.ready <= ($urandom_range(0, 9) < 7);
				2: rsp.ready <= ($urandom_range(0, 3) == 0);
				default: rsp.ready <= (cyc % 5 == 0);
			endcase
			cyc++;
		end
	end

	// Compare every result transfer with the oldest expectation.
	always @(posedge clk) begin
		rsp_item_t want;
		if (arst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
			if (awaited_results.size() == 0) begin
				note_mismatch("result with none outstanding", 32'h0, {30'h0, rsp.data.status});
			end else begin
				want = awaited_results.pop_front();
				if (rsp.data.status !== want.status)
					note_mismatch("status", 32'(want.status), 32'(rsp.data.status));
				if (rsp.data.served_tag !== want.served_tag)
					note_mismatch("served_tag", 32'(want.served_tag),
						32'(rsp.data.served_tag));
				if (rsp.data.served_level !== want.served_level)
					note_mismatch("served_level", 32'(want.served_level),
						32'(rsp.data.served_level));
				if (rsp.data.served_time !== want.served_time)
					note_mismatch("served_time", want.served_time, rsp.data.served_time);
			end
		end
	end

	// Watchdog: end the run after too many cycles without any transfer.
	always @(posedge clk) begin
		if ((req.valid === 1'b1 && req.ready === 1'b1) ||
				(rsp.valid === 1'b1 && rsp.ready === 1'b1))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Main sequence: reset, directed table, random traffic, drain.
	initial begin
		int        insert_pct;
		int        lvl_lo;
		int        lvl_hi;
		int        time_mode;
		req_item_t it;
		req.valid = 1'b0;
		req.data  = '0;
		arst_n    = 1'b0;
		for (int i = 0; i < LEVELS; i++)
			depth_used[i] = 0;

		// Empty serve, out-of-range levels, extremes and equal-time order.
		plan_row(KIND_SERVE, 16'h0000, 4'd0, 32'h0, 1'b1, ST_EMPTY);
		plan_row(KIND_INSERT, 16'h1111, 4'd0, 32'd10, 1'b1, ST_DROPPED);
		plan_row(KIND_INSERT, 16'h2222, 4'd15, 32'd10, 1'b1, ST_DROPPED);
		plan_row(KIND_INSERT, 16'hFFFF, 4'd8, 32'hFFFF_FFFF, 1'b1, ST_INSERTED);
		plan_row(KIND_INSERT, 16'h0000, 4'd8, 32'h0, 1'b1, ST_INSERTED);
		plan_row(KIND_INSERT, 16'h1234, 4'd8, 32'hFFFF_FFFF, 1'b1, ST_INSERTED);
		plan_row(KIND_INSERT, 16'hAAAA, 4'd1, 32'h5555_5555, 1'b1, ST_INSERTED);
		for (int i = 0; i < 4; i++)
			plan_row(KIND_SERVE, 16'hFFFF, 4'd15, 32'hFFFF_FFFF, 1'b0, ST_EMPTY);
		plan_row(KIND_SERVE, 16'h0000, 4'd0, 32'h0, 1'b1, ST_EMPTY);
		// Fill one level, then one insert more is dropped.
		for (int i = 0; i < LEVEL_DEPTH; i++)
			plan_row(KIND_INSERT, 16'(16'h2000 + i), 4'd2, 32'(1000 - 37 * i), 1'b1,
				ST_INSERTED);
		plan_row(KIND_INSERT, 16'h2FFF, 4'd2, 32'd500, 1'b1, ST_DROPPED);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[i])
			send_item(directed_plan[i].item, directed_plan[i].typed,
				directed_plan[i].want_status);

		// Random sections switch at random between filling, balanced and draining mixes.
		insert_pct = 50;
		lvl_lo     = 1;
		lvl_hi     = LEVELS;
		time_mode  = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 30 == 0) begin
				case ($urandom_range(0, 2))
					0: insert_pct = 85;
					1: insert_pct = 50;
					default: insert_pct = 20;
				endcase
				if ($urandom_range(0, 1) == 0) begin
					lvl_lo = 1;
					lvl_hi = LEVELS;
				end else begin
					lvl_lo = $urandom_range(1, LEVELS);
					lvl_hi = ($urandom_range(0, 1) == 0) ? lvl_lo :
						((lvl_lo < LEVELS) ? lvl_lo + 1 : lvl_lo);
				end
				time_mode = $urandom_range(0, 2);
			end
			it = random_item(insert_pct, lvl_lo, lvl_hi, time_mode);
			send_item(it, 1'b0, ST_EMPTY);
		end
		req.valid <= 1'b0;

		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
